// File: src/bgc_pkg.sv
`default_nettype none
package bgc_pkg;

  localparam int MAX_VERTICES = 256;
  localparam int MAX_EDGES    = 1024;
  localparam int VW           = $clog2(MAX_VERTICES);
  localparam int EW           = $clog2(MAX_EDGES);

  localparam logic [1:0] MARK_NONE = 2'd0;
  localparam logic [1:0] MARK_A    = 2'd1;
  localparam logic [1:0] MARK_B    = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_RANGE    = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  typedef struct packed {
    logic       edge_valid;
    logic [7:0] end_one;
    logic [7:0] end_two;
    logic       last;
  } in_t;

  typedef struct packed {
    logic       is_bipartite;
    logic [1:0] status;
  } out_t;

endpackage
`default_nettype wire

// File: src/bipartite_graph_check.sv
// Bipartite check by two-coloring.
// Input channel (in_valid/in_ready/in_data): one edge request per item; an
// item with last set closes the graph and starts the check. Edge items are
// taken one per cycle while the block is loading.
// Result channel (out_valid/out_ready/out_data): one verdict per graph, held
// in an output register until taken; the next graph's edges load meanwhile.
// Config channel (cfg_valid/cfg_ready/cfg_data): vertex_count, always ready.
// Order of work after the closing item: each root candidate is read and
// checked; for every colored vertex it is popped, its color read, then
// every stored edge read and checked, with one more check per edge touching
// it; each component ends in an empty pop; then the verdict is loaded. The
// edge memory read port sets the pace. A graph with an error skips the walk.
// Reset clears the edge count, colors, error and sets vertex_count to 256.
// A stalled receiver holds the verdict; a further verdict waits for it.
`default_nettype none
module bipartite_graph_check (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire bgc_pkg::in_t   in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output bgc_pkg::out_t       out_data,
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire logic [8:0]     cfg_data
);

  localparam int VW = bgc_pkg::VW;
  localparam int EW = bgc_pkg::EW;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_ROOT_RD  = 4'd1;
  localparam logic [3:0] S_ROOT_CHK = 4'd2;
  localparam logic [3:0] S_POP      = 4'd3;
  localparam logic [3:0] S_POP_W    = 4'd4;
  localparam logic [3:0] S_UCOL     = 4'd5;
  localparam logic [3:0] S_EDGE_RD  = 4'd6;
  localparam logic [3:0] S_EDGE_CHK = 4'd7;
  localparam logic [3:0] S_V_CHK    = 4'd8;
  localparam logic [3:0] S_DONE     = 4'd9;

  logic [3:0]    state_r, state_nxt;
  logic [8:0]    vcount_r;
  logic [EW:0]   total_r, total_nxt;
  logic [1:0]    err_r, err_nxt;
  logic          ok_r, ok_nxt;
  logic [VW:0]   root_r, root_nxt;
  logic [VW:0]   sp_r, sp_nxt;
  logic [EW:0]   e_r, e_nxt;
  logic [VW-1:0] u_r, u_nxt, v_r, v_nxt;
  logic [1:0]    cu_r, cu_nxt;
  logic          out_valid_r, out_valid_nxt;
  bgc_pkg::out_t out_r, out_nxt;

  logic [15:0]   edge_mem [bgc_pkg::MAX_EDGES];
  logic [15:0]   edge_q;
  logic [1:0]    col_mem [bgc_pkg::MAX_VERTICES];
  logic [1:0]    col_q;
  logic [bgc_pkg::MAX_VERTICES-1:0] col_vld_r, col_vld_nxt;
  logic          vld_q;
  logic [VW-1:0] stk_mem [bgc_pkg::MAX_VERTICES];
  logic [VW-1:0] stk_q;

  logic          edge_we, col_we, stk_we;
  logic [VW-1:0] col_ra, col_wa, stk_wd;
  logic [1:0]    col_wd;
  logic [VW:0]   live_n;
  logic          accept, in_range;
  logic [1:0]    col_cur, other;
  logic [7:0]    ea, eb;
  logic [VW:0]   root_inc;
  logic [EW:0]   e_inc;

  assign live_n   = (vcount_r > 9'(bgc_pkg::MAX_VERTICES)) ?
                    (VW+1)'(bgc_pkg::MAX_VERTICES) : (VW+1)'(vcount_r);
  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign in_range = ((VW+1)'(in_data.end_one) < live_n) &&
                    ((VW+1)'(in_data.end_two) < live_n);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign col_cur  = vld_q ? col_q : bgc_pkg::MARK_NONE;
  assign other    = (cu_r == bgc_pkg::MARK_A) ? bgc_pkg::MARK_B : bgc_pkg::MARK_A;
  assign ea       = edge_q[7:0];
  assign eb       = edge_q[15:8];
  assign root_inc = root_r + 1'b1;
  assign e_inc    = e_r + 1'b1;

  always_comb begin
    state_nxt     = state_r;
    total_nxt     = total_r;
    err_nxt       = err_r;
    ok_nxt        = ok_r;
    root_nxt      = root_r;
    sp_nxt        = sp_r;
    e_nxt         = e_r;
    u_nxt         = u_r;
    v_nxt         = v_r;
    cu_nxt        = cu_r;
    col_vld_nxt   = col_vld_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    edge_we       = 1'b0;
    col_we        = 1'b0;
    col_wa        = root_r[VW-1:0];
    col_wd        = bgc_pkg::MARK_A;
    col_ra        = root_r[VW-1:0];
    stk_we        = 1'b0;
    stk_wd        = root_r[VW-1:0];
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_data.edge_valid) begin
            if (!in_range) begin
              if (err_r == bgc_pkg::ST_OK) err_nxt = bgc_pkg::ST_RANGE;
            end else if (total_r >= (EW+1)'(bgc_pkg::MAX_EDGES)) begin
              if (err_r == bgc_pkg::ST_OK) err_nxt = bgc_pkg::ST_OVERFLOW;
            end else begin
              edge_we   = 1'b1;
              total_nxt = total_r + 1'b1;
            end
          end
          if (in_data.last) begin
            root_nxt = '0;
            sp_nxt   = '0;
            if (err_nxt != bgc_pkg::ST_OK) begin
              ok_nxt    = 1'b0;
              state_nxt = S_DONE;
            end else if (live_n == '0) begin
              ok_nxt    = 1'b1;
              state_nxt = S_DONE;
            end else begin
              ok_nxt    = 1'b1;
              state_nxt = S_ROOT_RD;
            end
          end
        end
      end
      S_ROOT_RD: begin
        col_ra    = root_r[VW-1:0];
        state_nxt = S_ROOT_CHK;
      end
      S_ROOT_CHK: begin
        if (col_cur == bgc_pkg::MARK_NONE) begin
          col_we = 1'b1;
          col_wa = root_r[VW-1:0];
          col_wd = bgc_pkg::MARK_A;
          col_vld_nxt[root_r[VW-1:0]] = 1'b1;
          stk_we    = 1'b1;
          stk_wd    = root_r[VW-1:0];
          sp_nxt    = sp_r + 1'b1;
          state_nxt = S_POP;
        end else begin
          root_nxt  = root_inc;
          state_nxt = (root_inc == live_n) ? S_DONE : S_ROOT_RD;
        end
      end
      S_POP: begin
        if (sp_r == '0) begin
          root_nxt  = root_inc;
          state_nxt = (root_inc == live_n) ? S_DONE : S_ROOT_RD;
        end else begin
          sp_nxt    = sp_r - 1'b1;
          state_nxt = S_POP_W;
        end
      end
      S_POP_W: begin
        col_ra    = stk_q;
        u_nxt     = stk_q;
        state_nxt = S_UCOL;
      end
      S_UCOL: begin
        cu_nxt    = col_cur;
        e_nxt     = '0;
        state_nxt = (total_r == '0) ? S_POP : S_EDGE_RD;
      end
      S_EDGE_RD: begin
        state_nxt = S_EDGE_CHK;
      end
      S_EDGE_CHK: begin
        if (ea == 8'(u_r) || eb == 8'(u_r)) begin
          v_nxt     = (ea == 8'(u_r)) ? VW'(eb) : VW'(ea);
          col_ra    = (ea == 8'(u_r)) ? VW'(eb) : VW'(ea);
          state_nxt = S_V_CHK;
        end else begin
          e_nxt     = e_inc;
          state_nxt = (e_inc == total_r) ? S_POP : S_EDGE_RD;
        end
      end
      S_V_CHK: begin
        e_nxt     = e_inc;
        state_nxt = (e_inc == total_r) ? S_POP : S_EDGE_RD;
        if (col_cur == bgc_pkg::MARK_NONE) begin
          col_we = 1'b1;
          col_wa = v_r;
          col_wd = other;
          col_vld_nxt[v_r] = 1'b1;
          stk_we = 1'b1;
          stk_wd = v_r;
          sp_nxt = sp_r + 1'b1;
        end else if (col_cur == cu_r) begin
          ok_nxt    = 1'b0;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.is_bipartite = ok_r && (err_r == bgc_pkg::ST_OK);
          out_nxt.status       = err_r;
          out_valid_nxt        = 1'b1;
          total_nxt            = '0;
          err_nxt              = bgc_pkg::ST_OK;
          col_vld_nxt          = '0;
          sp_nxt               = '0;
          state_nxt            = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vcount_r    <= 9'(bgc_pkg::MAX_VERTICES);
      total_r     <= '0;
      err_r       <= bgc_pkg::ST_OK;
      ok_r        <= 1'b0;
      root_r      <= '0;
      sp_r        <= '0;
      e_r         <= '0;
      col_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      err_r       <= err_nxt;
      ok_r        <= ok_nxt;
      root_r      <= root_nxt;
      sp_r        <= sp_nxt;
      e_r         <= e_nxt;
      col_vld_r   <= col_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        vcount_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    u_r   <= u_nxt;
    v_r   <= v_nxt;
    cu_r  <= cu_nxt;
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (edge_we) begin
      edge_mem[total_r[EW-1:0]] <= {in_data.end_two, in_data.end_one};
    end
    edge_q <= edge_mem[e_r[EW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (col_we) begin
      col_mem[col_wa] <= col_wd;
    end
    col_q <= col_mem[col_ra];
    vld_q <= col_vld_r[col_ra];
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[sp_r[VW-1:0]] <= stk_wd;
    end
    stk_q <= stk_mem[VW'(sp_r - 1'b1)];
  end

  a_verdict_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.is_bipartite |-> out_r.status == bgc_pkg::ST_OK)
    else $error("bipartite verdict with error status");

  a_total_cap: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= (EW+1)'(bgc_pkg::MAX_EDGES))
    else $error("edge count beyond capacity");

  a_stack_cap: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= (VW+1)'(bgc_pkg::MAX_VERTICES))
    else $error("walk stack beyond capacity");

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    $past(state_r) == S_DONE && state_r == S_IDLE |-> sp_r == '0 && err_r == bgc_pkg::ST_OK)
    else $error("graph state not cleared after verdict");

endmodule
`default_nettype wire

// File: sim/testbench.sv
`timescale 1ns / 100ps
`default_nettype none
module testbench;

  localparam int WATCH_LIMIT = 4000000;
  localparam int HOLD_LEN    = 600;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  bgc_pkg::in_t  in_data;
  logic out_valid;
  logic out_ready;
  bgc_pkg::out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [8:0] cfg_data;

  bipartite_graph_check uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // predictor state
  int          vcount;
  logic [15:0] edge_mem [0:bgc_pkg::MAX_EDGES-1];
  int          edge_cnt;
  logic [1:0]  err_code;
  logic [1:0]  mark [0:bgc_pkg::MAX_VERTICES-1];
  int          walk [0:bgc_pkg::MAX_VERTICES-1];
  bgc_pkg::out_t verdict_q [$];

  int n_items, n_graphs, n_verdicts, n_cfg, n_mismatch;
  int burst_left;
  bit hold_req;
  int idle_cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic bit colour_from(int root);
    int depth, u, v, a, b;
    logic [1:0] other;
    depth = 0;
    mark[root] = bgc_pkg::MARK_A;
    walk[depth] = root;
    depth++;
    while (depth > 0) begin
      depth--;
      u = walk[depth];
      other = (mark[u] == bgc_pkg::MARK_A) ? bgc_pkg::MARK_B : bgc_pkg::MARK_A;
      for (int e = 0; e < edge_cnt; e++) begin
        a = edge_mem[e][7:0];
        b = edge_mem[e][15:8];
        if (a == u) v = b;
        else if (b == u) v = a;
        else continue;
        if (mark[v] == bgc_pkg::MARK_NONE) begin
          mark[v] = other;
          if (depth < bgc_pkg::MAX_VERTICES) begin
            walk[depth] = v;
            depth++;
          end
        end else if (mark[v] == mark[u]) begin
          return 1'b0;
        end
      end
    end
    return 1'b1;
  endfunction

  function automatic void take_request(bgc_pkg::in_t it);
    int n;
    bit ok;
    bgc_pkg::out_t r;
    n = (vcount < bgc_pkg::MAX_VERTICES) ? vcount : bgc_pkg::MAX_VERTICES;
    if (it.edge_valid) begin
      if (it.end_one >= n || it.end_two >= n) begin
        if (err_code == bgc_pkg::ST_OK) err_code = bgc_pkg::ST_RANGE;
      end else if (edge_cnt >= bgc_pkg::MAX_EDGES) begin
        if (err_code == bgc_pkg::ST_OK) err_code = bgc_pkg::ST_OVERFLOW;
      end else begin
        edge_mem[edge_cnt] = {it.end_two, it.end_one};
        edge_cnt++;
      end
    end
    if (it.last) begin
      ok = 1'b1;
      for (int i = 0; i < n && ok; i++)
        if (mark[i] == bgc_pkg::MARK_NONE) ok = colour_from(i);
      r.is_bipartite = ok && (err_code == bgc_pkg::ST_OK);
      r.status = err_code;
      verdict_q.push_back(r);
      edge_cnt = 0;
      err_code = bgc_pkg::ST_OK;
      for (int i = 0; i < bgc_pkg::MAX_VERTICES; i++) mark[i] = bgc_pkg::MARK_NONE;
      n_graphs++;
    end
  endfunction

  task automatic send(input bit ev, input int a, input int b, input bit lst);
    bgc_pkg::in_t it;
    it.edge_valid = ev;
    it.end_one = a[7:0];
    it.end_two = b[7:0];
    it.last = lst;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 20);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    take_request(it);
    n_items++;
  endtask

  task automatic send_edge(input int a, input int b, input bit lst);
    send(1'b1, a, b, lst);
  endtask

  task automatic write_vcount(input int value);
    in_valid <= 1'b0;
    wait (verdict_q.size() == 0);
    repeat (40) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value[8:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    vcount = value & 9'h1FF;
    n_cfg++;
  endtask

  // receiver: pattern of its own, plus one long hold on request
  initial begin
    int phase;
    int hold_cnt;
    bit held;
    out_ready = 1'b0;
    phase = 0;
    hold_cnt = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      phase++;
      if (hold_req && !held) begin
        held = 1'b1;
        hold_cnt = HOLD_LEN;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready <= 1'b0;
      end else begin
        case ((phase / 97) % 3)
          0: out_ready <= 1'b1;
          1: out_ready <= $urandom_range(0, 1);
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    bgc_pkg::out_t want;
    if (rst_n && out_valid && out_ready) begin
      n_verdicts++;
      if (verdict_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("unexpected verdict: got bip=%0d status=%0d",
                   out_data.is_bipartite, out_data.status);
      end else begin
        want = verdict_q.pop_front();
        if (want.is_bipartite !== out_data.is_bipartite || want.status !== out_data.status) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("verdict %0d mismatch: expected bip=%0d status=%0d, got bip=%0d status=%0d",
                     n_verdicts, want.is_bipartite, want.status,
                     out_data.is_bipartite, out_data.status);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic test_directed();
    write_vcount(256);
    send(1'b0, 0, 0, 1'b1);
    send_edge(7, 7, 1'b1);
    send_edge(0, 1, 1'b0);
    send_edge(1, 2, 1'b0);
    send_edge(2, 0, 1'b1);
    send_edge(0, 1, 1'b0);
    send_edge(1, 2, 1'b0);
    send_edge(2, 3, 1'b0);
    send(1'b0, 255, 255, 1'b0);
    send_edge(3, 0, 1'b1);
    send_edge(255, 170, 1'b0);
    send_edge(85, 254, 1'b1);
    write_vcount(4);
    send_edge(1, 4, 1'b0);
    send_edge(0, 1, 1'b1);
    send_edge(0, 1, 1'b0);
    send_edge(4, 0, 1'b0);
    send_edge(1, 1, 1'b1);
    write_vcount(0);
    send_edge(0, 0, 1'b1);
    send(1'b0, 0, 0, 1'b1);
  endtask

  task automatic test_config_extremes();
    int vals [6] = '{1, 2, 3, 511, 257, 255};
    foreach (vals[k]) begin
      write_vcount(vals[k]);
      send_edge(0, $urandom_range(0, 3), 1'b0);
      send_edge($urandom_range(0, 2), 1, 1'b0);
      send_edge(255, 0, 1'b1);
      send_edge(0, 1, 1'b1);
    end
  endtask

  task automatic test_overflow();
    write_vcount(100);
    for (int i = 0; i < bgc_pkg::MAX_EDGES + 1; i++)
      send_edge($urandom_range(0, 99), $urandom_range(0, 99), 1'b0);
    send_edge(99, 100, 1'b1);
  endtask

  task automatic random_graph(input int max_edges);
    int n, ne, a, b, sel;
    int side [0:bgc_pkg::MAX_VERTICES-1];
    n = (vcount < bgc_pkg::MAX_VERTICES) ? vcount : bgc_pkg::MAX_VERTICES;
    for (int i = 0; i < bgc_pkg::MAX_VERTICES; i++) side[i] = $urandom_range(0, 1);
    ne = $urandom_range(0, max_edges);
    for (int k = 0; k <= ne; k++) begin
      sel = $urandom_range(0, 99);
      a = (n > 0) ? $urandom_range(0, n - 1) : 0;
      b = (n > 0) ? $urandom_range(0, n - 1) : 0;
      if (sel < 70) begin
        for (int t = 0; t < 8 && side[a] == side[b] && n > 1; t++)
          b = $urandom_range(0, n - 1);
        send_edge(a, b, k == ne);
      end else if (sel < 88) begin
        send_edge(a, b, k == ne);
      end else if (sel < 95) begin
        send(1'b0, $urandom_range(0, 255), $urandom_range(0, 255), k == ne);
      end else begin
        send_edge($urandom_range(0, 255), $urandom_range(0, 255), k == ne);
      end
    end
  endtask

  task automatic test_pressure();
    write_vcount(12);
    hold_req = 1'b1;
    for (int g = 0; g < 25; g++) random_graph(6);
  endtask

  task automatic test_random();
    int vc;
    for (int p = 0; p < 24; p++) begin
      case ($urandom_range(0, 5))
        0: vc = 256;
        1: vc = $urandom_range(257, 511);
        2: vc = $urandom_range(1, 4);
        default: vc = $urandom_range(5, 40);
      endcase
      write_vcount(vc);
      for (int g = 0; g < 4; g++) random_graph((vc >= 256) ? 4 : 9);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    hold_req = 1'b0;
    burst_left = 0;
    n_items = 0; n_graphs = 0; n_verdicts = 0; n_cfg = 0; n_mismatch = 0;
    vcount = 256;
    edge_cnt = 0;
    err_code = bgc_pkg::ST_OK;
    for (int i = 0; i < bgc_pkg::MAX_VERTICES; i++) mark[i] = bgc_pkg::MARK_NONE;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_config_extremes();
    test_pressure();
    test_random();
    test_overflow();

    in_valid <= 1'b0;
    wait (verdict_q.size() == 0);
    repeat (100) @(posedge clk);
    $display("ran %0d edge requests over %0d graphs with %0d vertex-count writes,",
             n_items, n_graphs, n_cfg);
    $display("checked %0d verdicts, %0d mismatches", n_verdicts, n_mismatch);
    if (n_mismatch == 0 && verdict_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire
